@@ sv/ulaq_pkg.sv @@
// Shared constants for the serial line assembler queue.
package ulaq_pkg;

  localparam int unsigned LINE_CHARS_DEF  = 64;
  localparam int unsigned QUEUE_LINES_DEF = 8;
  localparam int unsigned CHAR_W          = 8;

  // Request action codes
  localparam logic [1:0] ACT_RECV  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_FLAGS = 2'd2;

  // Result kind codes
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_FLAGS = 2'd2;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

endpackage

@@ sv/uart_line_assembler_queue.sv @@
// Serial command line assembler with a queue of whole lines (top level).
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   in       | in_valid/in_stall  | in_action, in_rx_byte, in_line_error
//   out      | out_valid/out_stall| out_kind, out_char_out, out_last, out_*_flag
//
// A receive request is handled in the idle state; the open line is assembled
// directly in a free slot of the character memory, so ending a line needs no
// copy. A flag read or a pop on an empty queue passes through S_EMIT; a pop of
// a line passes through S_LEN and then S_CHAR, paced by the character memory
// read port. Reset clears only the state, pointers, counts and flags; the memories
// need no clearing. A stalled output holds its result; new requests wait until the
// current one has handed over its last result to the output register.
module uart_line_assembler_queue import ulaq_pkg::*; #(
  parameter int unsigned LINE_CHARS  = LINE_CHARS_DEF,
  parameter int unsigned QUEUE_LINES = QUEUE_LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [CHAR_W-1:0] in_rx_byte,
  input  logic              in_line_error,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_last,
  output logic              out_rx_error_flag,
  output logic              out_too_long_flag,
  output logic              out_overflow_flag
);

  // one slot more than queue lines: the tail slot holds the line being typed
  localparam int unsigned SLOTS       = QUEUE_LINES + 1;
  localparam int unsigned SLOT_W      = $clog2(SLOTS);
  localparam int unsigned POS_W       = $clog2(LINE_CHARS);
  localparam int unsigned CNT_W       = $clog2(QUEUE_LINES + 1);
  localparam int unsigned CHARS_DEPTH = SLOTS * LINE_CHARS;
  localparam int unsigned CA_W        = $clog2(CHARS_DEPTH);
  localparam int unsigned MAX_LEN     = LINE_CHARS - 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EMIT = 4'b0010,
    S_LEN  = 4'b0100,
    S_CHAR = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   line_len_r, line_len_nxt;
  logic               last_cr_r, last_cr_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [SLOT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               err_r, err_nxt;
  logic               long_r, long_nxt;
  logic               ovf_r, ovf_nxt;
  logic [1:0]         pend_kind_r, pend_kind_nxt;
  logic [2:0]         pend_flags_r, pend_flags_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   pop_len_r, pop_len_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [2:0]         out_flags_r, out_flags_nxt;

  logic               out_free;
  logic               cw_en;
  logic [CA_W-1:0]    cw_addr;
  logic [CA_W-1:0]    cr_addr;
  logic [CHAR_W-1:0]  cr_data;
  logic               lw_en;
  logic [POS_W-1:0]   lr_data;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign cw_addr = CA_W'(tail_r) * CA_W'(LINE_CHARS) + CA_W'(line_len_r);
  assign cr_addr = CA_W'(head_r) * CA_W'(LINE_CHARS) + CA_W'(pos_nxt);

  ulaq_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CHARS_DEPTH)
  ) u_chars (
    .clk     (clk),
    .wr_en   (cw_en),
    .wr_addr (cw_addr),
    .wr_data (in_rx_byte),
    .rd_addr (cr_addr),
    .rd_data (cr_data)
  );

  ulaq_ram #(
    .WIDTH (POS_W),
    .DEPTH (SLOTS)
  ) u_lens (
    .clk     (clk),
    .wr_en   (lw_en),
    .wr_addr (tail_r),
    .wr_data (line_len_r),
    .rd_addr (head_r),
    .rd_data (lr_data)
  );

  always_comb begin
    logic finish;
    logic pop_last;
    finish         = 1'b0;
    pop_last       = 1'b0;
    state_nxt      = state_r;
    line_len_nxt   = line_len_r;
    last_cr_nxt    = last_cr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    err_nxt        = err_r;
    long_nxt       = long_r;
    ovf_nxt        = ovf_r;
    pend_kind_nxt  = pend_kind_r;
    pend_flags_nxt = pend_flags_r;
    pos_nxt        = pos_r;
    pop_len_nxt    = pop_len_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_flags_nxt  = out_flags_r;
    cw_en          = 1'b0;
    lw_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_RECV: begin
              if (in_line_error) begin
                err_nxt = 1'b1;
              end
              if (in_rx_byte == CH_CR) begin
                finish      = 1'b1;
                last_cr_nxt = 1'b1;
              end else if (in_rx_byte == CH_LF) begin
                // LF right after CR is swallowed
                if (last_cr_r) begin
                  last_cr_nxt = 1'b0;
                end else begin
                  finish = 1'b1;
                end
              end else begin
                last_cr_nxt = 1'b0;
                if (in_rx_byte == CH_BS || in_rx_byte == CH_DEL) begin
                  if (line_len_r != '0) begin
                    line_len_nxt = line_len_r - POS_W'(1);
                  end
                end else if (in_rx_byte >= CH_SPACE && in_rx_byte <= CH_TILDE) begin
                  if (line_len_r < POS_W'(MAX_LEN)) begin
                    cw_en        = 1'b1;
                    line_len_nxt = line_len_r + POS_W'(1);
                  end else begin
                    line_len_nxt = '0;
                    long_nxt     = 1'b1;
                  end
                end
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                pend_kind_nxt  = KIND_EMPTY;
                pend_flags_nxt = '0;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_LEN;
              end
            end
            ACT_FLAGS: begin
              pend_kind_nxt  = KIND_FLAGS;
              pend_flags_nxt = {err_r, long_r, ovf_r};
              err_nxt        = 1'b0;
              long_nxt       = 1'b0;
              ovf_nxt        = 1'b0;
              state_nxt      = S_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_flags_nxt = pend_flags_r;
          state_nxt     = S_IDLE;
        end
      end
      S_LEN: begin
        // length of head line is ready; start reading its first character
        pop_len_nxt = lr_data;
        pos_nxt     = '0;
        state_nxt   = S_CHAR;
      end
      S_CHAR: begin
        pop_last = ((pos_r + POS_W'(1)) == pop_len_r);
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CHAR;
          out_char_nxt  = cr_data;
          out_last_nxt  = pop_last;
          out_flags_nxt = '0;
          if (pop_last) begin
            head_nxt  = (head_r == SLOT_W'(SLOTS - 1)) ? '0 : head_r + SLOT_W'(1);
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_IDLE;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // line end: commit a non-empty open slot, or drop it when the queue is full
    if (finish && line_len_r != '0) begin
      if (count_r == CNT_W'(QUEUE_LINES)) begin
        ovf_nxt = 1'b1;
      end else begin
        lw_en     = 1'b1;
        tail_nxt  = (tail_r == SLOT_W'(SLOTS - 1)) ? '0 : tail_r + SLOT_W'(1);
        count_nxt = count_r + CNT_W'(1);
      end
      line_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      line_len_r  <= '0;
      last_cr_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      err_r       <= 1'b0;
      long_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_len_r  <= line_len_nxt;
      last_cr_r   <= last_cr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      long_r      <= long_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r  <= pend_kind_nxt;
    pend_flags_r <= pend_flags_nxt;
    pos_r        <= pos_nxt;
    pop_len_r    <= pop_len_nxt;
    out_kind_r   <= out_kind_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_flags_r  <= out_flags_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_char_out      = out_char_r;
  assign out_last          = out_last_r;
  assign out_rx_error_flag = out_flags_r[2];
  assign out_too_long_flag = out_flags_r[1];
  assign out_overflow_flag = out_flags_r[0];

endmodule

@@ sv/ulaq_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module ulaq_ram import ulaq_pkg::*; #(
  parameter int unsigned WIDTH = CHAR_W,
  parameter int unsigned DEPTH = LINE_CHARS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
